### sv/slmd_pkg.sv
package slmd_pkg;

  // Fixed field widths
  localparam int ADC_W    = 12;
  localparam int HEIGHT_W = 7;
  localparam int DECAY_W  = 7;
  localparam int CFG_W    = 2;

  // Defaults for the top-level parameters
  localparam int SEGMENTS_DEF            = 8;
  localparam int SAMPLES_PER_SEGMENT_DEF = 4;

  // Register reset values and height limits
  localparam logic [ADC_W-1:0]    CENTER_RESET = 12'd2267;
  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 7'd7;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 7'd127;
  localparam logic [HEIGHT_W-1:0] HEIGHT_FLOOR = 7'd2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_CENTER_LEVEL = 2'd0;
  localparam logic [CFG_W-1:0] CFG_DECAY_STEP   = 2'd1;

  // Gain over 2048: low = 64, mid = 96, high = 128
  typedef enum logic [1:0] {
    GAIN_LOW,
    GAIN_MID,
    GAIN_HIGH
  } gain_t;

  // Gain from the bar's distance to the nearer end of the row
  function automatic gain_t position_gain(input int unsigned seg, input int unsigned segments);
    int unsigned from_end;
    int unsigned d;
    from_end = segments - 1 - seg;
    d = (seg < from_end) ? seg : from_end;
    if (d == 0) begin
      return GAIN_LOW;
    end else if (d + 1 >= (segments >> 1)) begin
      return GAIN_HIGH;
    end
    return GAIN_MID;
  endfunction

  // avg * gain / 2048, clamped to the top of the bar
  function automatic logic [HEIGHT_W-1:0] scale_height(input logic [ADC_W-1:0] avg,
                                                        input gain_t g);
    logic [ADC_W+1:0] x3;
    logic [8:0]       v;
    x3 = {2'b00, avg} + {1'b0, avg, 1'b0};
    case (g)
      GAIN_LOW:  v = {2'b00, avg[11:5]};
      GAIN_MID:  v = {1'b0, x3[13:6]};
      GAIN_HIGH: v = {1'b0, avg[11:4]};
      default:   v = '0;
    endcase
    return (v > 9'(HEIGHT_MAX)) ? HEIGHT_MAX : v[HEIGHT_W-1:0];
  endfunction

endpackage

### sv/slmd_bar_update.sv
module slmd_bar_update
  import slmd_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF,
  localparam int SEG_W   = $clog2(SEGMENTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [DECAY_W-1:0]  decay_step,
  input  logic                avg_valid,
  input  logic [ADC_W-1:0]    avg,
  input  logic [SEG_W-1:0]    avg_seg,
  output logic                avg_taken,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [SEG_W-1:0]    segment_index,
  output logic [HEIGHT_W-1:0] bar_height,
  output logic                frame_end
);

  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

  logic [HEIGHT_W-1:0] bar_store [SEGMENTS];
  logic [HEIGHT_W-1:0] fresh;
  logic [HEIGHT_W-1:0] old;
  logic [HEIGHT_W-1:0] fallen;
  logic [HEIGHT_W-1:0] upd;
  logic                load;

  // Output word is taken or empty: next word may enter
  assign load      = avg_valid & (~result_valid | ~result_stall);
  assign avg_taken = load;

  // Rise to the new height, or fall by the decay step down to the floor
  always_comb begin
    fresh  = scale_height(avg, position_gain(int'(avg_seg), SEGMENTS));
    old    = bar_store[avg_seg];
    fallen = (old > decay_step) ? old - decay_step : '0;
    if (fresh > old) begin
      upd = fresh;
    end else if (fallen < HEIGHT_FLOOR) begin
      upd = HEIGHT_FLOOR;
    end else begin
      upd = fallen;
    end
  end

  // Bar heights
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        bar_store[i] <= '0;
      end
    end else if (load) begin
      bar_store[avg_seg] <= upd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segment_index <= avg_seg;
      bar_height    <= upd;
      frame_end     <= (avg_seg == SEG_LAST);
    end
  end

endmodule

### sv/segmented_level_meter_decay_unit.sv
// Throughput: one sample per cycle while sample_stall is low; one result word per
// group of SAMPLES_PER_SEGMENT samples.
// A group's last sample passes through the input register, group total, average
// and output register in that order; result_stall can hold it between them.
// Reset (rst, synchronous): bars, frame position and running sum at 0,
// center_level = 2267, decay_step = 7.
module segmented_level_meter_decay_unit
  import slmd_pkg::*;
#(
  parameter int SEGMENTS            = SEGMENTS_DEF,
  parameter int SAMPLES_PER_SEGMENT = SAMPLES_PER_SEGMENT_DEF,
  localparam int SEG_W              = $clog2(SEGMENTS)
) (
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [ADC_W-1:0]    sample,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [SEG_W-1:0]    segment_index,
  output logic [HEIGHT_W-1:0] bar_height,
  output logic                frame_end,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_index,
  input  logic [ADC_W-1:0]    cfg_data
);

  localparam int SPS_LOG  = $clog2(SAMPLES_PER_SEGMENT);
  localparam int GRP_W    = (SAMPLES_PER_SEGMENT > 1) ? SPS_LOG : 1;
  localparam int SUM_W    = ADC_W + SPS_LOG;
  // Exact divide by the group size: ceil(2^RECIP_SH / N), then shift
  localparam int RECIP_SH = SUM_W + SPS_LOG;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint RECIP =
    ((longint'(1) << RECIP_SH) + SAMPLES_PER_SEGMENT - 1) / SAMPLES_PER_SEGMENT;
  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(SAMPLES_PER_SEGMENT - 1);
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

  logic [ADC_W-1:0]   center_level;
  logic [DECAY_W-1:0] decay_step;

  logic               smp_valid;
  logic [ADC_W-1:0]   smp;
  logic [GRP_W-1:0]   grp_cnt;
  logic [SEG_W-1:0]   seg_cnt;
  logic [SUM_W-1:0]   group_sum;
  logic [ADC_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_next;
  logic               grp_end;
  logic               in_go;

  logic               tot_valid;
  logic [SUM_W-1:0]   tot;
  logic [SEG_W-1:0]   tot_seg;
  logic               tot_load;
  logic               tot_free;

  logic               avg_valid;
  logic [ADC_W-1:0]   avg;
  logic [SEG_W-1:0]   avg_seg;
  logic               avg_free;
  logic               avg_taken;
  logic [PROD_W-1:0]  prod;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_level <= CENTER_RESET;
      decay_step   <= DECAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTER_LEVEL: center_level <= cfg_data;
        CFG_DECAY_STEP:   decay_step   <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow: each stage moves when the next one is empty or moving
  assign avg_free     = ~avg_valid | avg_taken;
  assign tot_load     = tot_valid & avg_free;
  assign tot_free     = ~tot_valid | tot_load;
  assign grp_end      = (grp_cnt == GRP_LAST);
  assign in_go        = smp_valid & (~grp_end | tot_free);
  assign sample_stall = smp_valid & ~in_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample_valid & ~sample_stall) begin
      smp_valid <= 1'b1;
    end else if (in_go) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid & ~sample_stall) begin
      smp <= sample;
    end
  end

  // Rectify and accumulate
  assign mag      = (smp >= center_level) ? smp - center_level : center_level - smp;
  assign sum_next = group_sum + SUM_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_cnt   <= '0;
      seg_cnt   <= '0;
      group_sum <= '0;
    end else if (in_go) begin
      if (grp_end) begin
        grp_cnt   <= '0;
        group_sum <= '0;
        seg_cnt   <= (seg_cnt == SEG_LAST) ? '0 : seg_cnt + 1'b1;
      end else begin
        grp_cnt   <= grp_cnt + 1'b1;
        group_sum <= sum_next;
      end
    end
  end

  // Group total
  always_ff @(posedge clk) begin
    if (rst) begin
      tot_valid <= 1'b0;
    end else if (in_go & grp_end) begin
      tot_valid <= 1'b1;
    end else if (tot_load) begin
      tot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go & grp_end) begin
      tot     <= sum_next;
      tot_seg <= seg_cnt;
    end
  end

  // Group average by reciprocal multiply
  assign prod = PROD_W'(tot) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (tot_load) begin
      avg_valid <= 1'b1;
    end else if (avg_taken) begin
      avg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_load) begin
      avg     <= prod[RECIP_SH +: ADC_W];
      avg_seg <= tot_seg;
    end
  end

  // Gain, rise or decay, and the output register
  slmd_bar_update #(
    .SEGMENTS (SEGMENTS)
  ) u_bar_update (
    .clk           (clk),
    .rst           (rst),
    .decay_step    (decay_step),
    .avg_valid     (avg_valid),
    .avg           (avg),
    .avg_seg       (avg_seg),
    .avg_taken     (avg_taken),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .segment_index (segment_index),
    .bar_height    (bar_height),
    .frame_end     (frame_end)
  );

endmodule
